// ----- sv/tcm_pkg.sv -----
package tcm_pkg;

  localparam int ACC_W = 40;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_CLIP   = 3'd1,
    REQ_SAMPLE = 3'd2,
    REQ_PLAY   = 3'd3,
    REQ_PAUSE  = 3'd4,
    REQ_STOP   = 3'd5,
    REQ_SEEK   = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    FLD_START  = 3'd0,
    FLD_LENGTH = 3'd1,
    FLD_BASE   = 3'd2,
    FLD_GAIN_L = 3'd3,
    FLD_GAIN_R = 3'd4,
    FLD_STEREO = 3'd5
  } clip_field_e;

  typedef enum logic [2:0] {
    CFG_PROJECT_LENGTH = 3'd0,
    CFG_LOOP_ENABLE    = 3'd1,
    CFG_LOOP_START     = 3'd2,
    CFG_LOOP_END       = 3'd3,
    CFG_MONITOR_ENABLE = 3'd4,
    CFG_MONITOR_STEREO = 3'd5
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_CLIPWR = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_PEAK   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] monitor_left;
    logic signed [15:0] monitor_right;
    logic               peak_clear;
    logic [2:0]         clip_index;
    logic [2:0]         clip_field;
    logic [31:0]        write_value;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic               out_valid;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [15:0]        peak_left;
    logic [15:0]        peak_right;
    logic               is_playing;
    logic [31:0]        playhead;
  } out_item_t;

  typedef struct packed {
    logic [31:0] project_length;
    logic        loop_enable;
    logic [31:0] loop_start;
    logic [31:0] loop_end;
    logic        monitor_enable;
    logic        monitor_stereo;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        start;
    logic [31:0]        length;
    logic [15:0]        base;
    logic signed [15:0] gain_l;
    logic signed [15:0] gain_r;
    logic               stereo;
  } clip_desc_t;

  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]  t;
    logic signed [ACC_W-13:0] q;
    t = acc + ACC_W'(2048);
    q = t[ACC_W-1:12];
    if (q > (ACC_W-12)'(32767)) begin
      return 16'sh7fff;
    end else if (q < -(ACC_W-12)'(32768)) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage

// ----- sv/tcm_clip_mem.sv -----
module tcm_clip_mem #(
  parameter int MAX_CLIPS = 8,
  parameter int CW        = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CW-1:0]         raddr_i,
  output tcm_pkg::clip_desc_t   rdata_o,
  input  logic                  we_i,
  input  logic [CW-1:0]         waddr_i,
  input  tcm_pkg::clip_desc_t   wdata_i
);

  tcm_pkg::clip_desc_t mem [MAX_CLIPS];
  logic [MAX_CLIPS-1:0] valid_q;
  tcm_pkg::clip_desc_t  rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // entries never written read as an inactive, all-zero clip
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ----- sv/tcm_sample_mem.sv -----
module tcm_sample_mem #(
  parameter int SAMPLE_DEPTH = 65536,
  parameter int AW           = 16
) (
  input  logic          clk_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i
);

  logic [31:0] mem [SAMPLE_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tcm_engine.sv -----
module tcm_engine #(
  parameter int MAX_CLIPS    = 8,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcm_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcm_pkg::in_item_t   in_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tcm_pkg::out_item_t  res_data_o
);

  localparam int CW = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
  localparam int NW = $clog2(MAX_CLIPS + 1);
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int AC = tcm_pkg::ACC_W;

  tcm_pkg::state_e    state_q, state_d;
  tcm_pkg::in_item_t  item_q;
  logic               playing_q, playing_d;
  logic [31:0]        pos_q, pos_d;
  logic [15:0]        peak_l_q, peak_l_d, peak_r_q, peak_r_d;
  logic signed [AC-1:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic signed [15:0] ol_q, ol_d, or_q, or_d;
  logic [NW-1:0]      iss_q, iss_d;
  logic               v1_q, v2_q, v3_q;
  logic               cov2_q, st2_q;
  logic signed [15:0] gl2_q, gr2_q;
  logic signed [31:0] p_l_q, p_r_q;

  tcm_pkg::clip_desc_t clip_rdata, clip_wdata;
  logic [CW-1:0]       clip_raddr;
  logic                clip_we;
  logic [31:0]         smp_rdata;
  logic [AW-1:0]       smp_raddr;
  logic                smp_we;

  logic               issuing, scan_done, covered, clip_ok;
  logic [31:0]        rel, pos_inc;
  logic signed [15:0] sl, sr;
  logic signed [AC-1:0] mon_l, mon_r;
  tcm_pkg::req_e      req;

  assign req = tcm_pkg::req_e'(item_q.req_type);

  tcm_clip_mem #(
    .MAX_CLIPS (MAX_CLIPS),
    .CW        (CW)
  ) u_clip_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (clip_raddr),
    .rdata_o (clip_rdata),
    .we_i    (clip_we),
    .waddr_i (CW'(item_q.clip_index)),
    .wdata_i (clip_wdata)
  );

  tcm_sample_mem #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .AW           (AW)
  ) u_sample_mem (
    .clk_i   (clk_i),
    .raddr_i (smp_raddr),
    .rdata_o (smp_rdata),
    .we_i    (smp_we),
    .waddr_i (AW'(item_q.sample_address)),
    .wdata_i ({item_q.sample_right, item_q.sample_left})
  );

  // clip scan: descriptor read, coverage and sample read, multiply, accumulate
  assign issuing    = (state_q == tcm_pkg::S_SCAN) && (iss_q < NW'(MAX_CLIPS));
  assign scan_done  = !issuing && !v1_q && !v2_q && !v3_q;
  assign clip_raddr = (state_q == tcm_pkg::S_EXEC) ? CW'(item_q.clip_index) : iss_q[CW-1:0];
  assign rel        = pos_q - clip_rdata.start;
  assign covered    = (pos_q >= clip_rdata.start) && (rel < clip_rdata.length);
  assign smp_raddr  = AW'(32'(clip_rdata.base) + rel);
  assign sl         = smp_rdata[15:0];
  assign sr         = st2_q ? smp_rdata[31:16] : smp_rdata[15:0];
  assign pos_inc    = pos_q + 32'd1;

  assign clip_ok = (32'(item_q.clip_index) < MAX_CLIPS) &&
                   (item_q.clip_field <= tcm_pkg::FLD_STEREO);
  assign clip_we = (state_q == tcm_pkg::S_CLIPWR);
  assign smp_we  = (state_q == tcm_pkg::S_EXEC) && (req == tcm_pkg::REQ_SAMPLE);

  always_comb begin
    clip_wdata = clip_rdata;
    unique case (tcm_pkg::clip_field_e'(item_q.clip_field))
      tcm_pkg::FLD_START:  clip_wdata.start  = item_q.write_value;
      tcm_pkg::FLD_LENGTH: clip_wdata.length = item_q.write_value;
      tcm_pkg::FLD_BASE:   clip_wdata.base   = item_q.write_value[15:0];
      tcm_pkg::FLD_GAIN_L: clip_wdata.gain_l = item_q.write_value[15:0];
      tcm_pkg::FLD_GAIN_R: clip_wdata.gain_r = item_q.write_value[15:0];
      tcm_pkg::FLD_STEREO: clip_wdata.stereo = item_q.write_value[0];
      default: ;
    endcase
  end

  always_comb begin
    mon_l = AC'(item_q.monitor_left);
    mon_r = cfg_i.monitor_stereo ? AC'(item_q.monitor_right) : AC'(item_q.monitor_left);
    mon_l = mon_l <<< 12;
    mon_r = mon_r <<< 12;
    if (!cfg_i.monitor_enable) begin
      mon_l = '0;
      mon_r = '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    playing_d = playing_q;
    pos_d     = pos_q;
    peak_l_d  = peak_l_q;
    peak_r_d  = peak_r_q;
    acc_l_d   = acc_l_q;
    acc_r_d   = acc_r_q;
    ol_d      = ol_q;
    or_d      = or_q;
    iss_d     = iss_q;
    if (issuing) begin
      iss_d = iss_q + NW'(1);
    end
    if (v3_q) begin
      acc_l_d = acc_l_q + AC'(p_l_q);
      acc_r_d = acc_r_q + AC'(p_r_q);
    end
    unique case (state_q)
      tcm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tcm_pkg::S_EXEC;
        end
      end
      tcm_pkg::S_EXEC: begin
        acc_l_d = mon_l;
        acc_r_d = mon_r;
        ol_d    = '0;
        or_d    = '0;
        iss_d   = '0;
        state_d = tcm_pkg::S_OUT;
        unique case (req)
          tcm_pkg::REQ_TICK: begin
            state_d = tcm_pkg::S_ROUND;
            if (playing_q) begin
              if (pos_q >= cfg_i.project_length) begin
                playing_d = 1'b0;
              end else begin
                state_d = tcm_pkg::S_SCAN;
              end
            end
          end
          tcm_pkg::REQ_CLIP: begin
            if (clip_ok) begin
              state_d = tcm_pkg::S_CLIPWR;
            end
          end
          tcm_pkg::REQ_PLAY:  playing_d = 1'b1;
          tcm_pkg::REQ_PAUSE: playing_d = 1'b0;
          tcm_pkg::REQ_STOP: begin
            playing_d = 1'b0;
            pos_d     = '0;
          end
          tcm_pkg::REQ_SEEK: pos_d = item_q.write_value;
          default: ;
        endcase
      end
      tcm_pkg::S_CLIPWR: begin
        state_d = tcm_pkg::S_OUT;
      end
      tcm_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = tcm_pkg::S_ROUND;
          if (cfg_i.loop_enable && (cfg_i.loop_end > cfg_i.loop_start) &&
              (pos_inc >= cfg_i.loop_end)) begin
            pos_d = cfg_i.loop_start;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
      tcm_pkg::S_ROUND: begin
        ol_d    = tcm_pkg::round_sat(acc_l_q);
        or_d    = tcm_pkg::round_sat(acc_r_q);
        state_d = tcm_pkg::S_PEAK;
      end
      tcm_pkg::S_PEAK: begin
        if (item_q.peak_clear || (tcm_pkg::abs16(ol_q) > peak_l_q)) begin
          peak_l_d = tcm_pkg::abs16(ol_q);
        end
        if (item_q.peak_clear || (tcm_pkg::abs16(or_q) > peak_r_q)) begin
          peak_r_d = tcm_pkg::abs16(or_q);
        end
        state_d = tcm_pkg::S_OUT;
      end
      tcm_pkg::S_OUT: begin
        if (res_ready_i) begin
          state_d = tcm_pkg::S_IDLE;
        end
      end
      default: state_d = tcm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcm_pkg::S_IDLE;
      playing_q <= 1'b0;
      pos_q     <= '0;
      peak_l_q  <= '0;
      peak_r_q  <= '0;
      iss_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      playing_q <= playing_d;
      pos_q     <= pos_d;
      peak_l_q  <= peak_l_d;
      peak_r_q  <= peak_r_d;
      iss_q     <= iss_d;
      v1_q      <= issuing;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    acc_l_q <= acc_l_d;
    acc_r_q <= acc_r_d;
    ol_q    <= ol_d;
    or_q    <= or_d;
    cov2_q  <= v1_q && covered;
    st2_q   <= clip_rdata.stereo;
    gl2_q   <= clip_rdata.gain_l;
    gr2_q   <= clip_rdata.gain_r;
    p_l_q   <= cov2_q ? sl * gl2_q : 32'sd0;
    p_r_q   <= cov2_q ? sr * gr2_q : 32'sd0;
  end

  assign in_ready_o  = (state_q == tcm_pkg::S_IDLE);
  assign res_valid_o = (state_q == tcm_pkg::S_OUT);

  always_comb begin
    res_data_o.out_valid  = (req == tcm_pkg::REQ_TICK);
    res_data_o.out_left   = ol_q;
    res_data_o.out_right  = or_q;
    res_data_o.peak_left  = peak_l_q;
    res_data_o.peak_right = peak_r_q;
    res_data_o.is_playing = playing_q;
    res_data_o.playhead   = pos_q;
  end

endmodule

// ----- sv/timeline_clip_mixer_unit.sv -----
// a tick while playing runs the clip scan, one descriptor and one sample-memory read
// per clip, before its result is ready; a new item is taken only after the last
// result has moved into the output register
// reset: transport, peaks, configuration and clip table clear at once; the sample
// memory is not cleared; SAMPLE_DEPTH must be a power of two, which the block
// itself does not enforce
module timeline_clip_mixer_unit #(
  parameter int MAX_CLIPS    = 8,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcm_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcm_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  tcm_pkg::cfg_t      cfg_q;
  logic               res_valid, res_ready;
  tcm_pkg::out_item_t res_data;
  logic               out_valid_q;
  tcm_pkg::out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tcm_pkg::cfg_idx_e'(cfg_index_i))
        tcm_pkg::CFG_PROJECT_LENGTH: cfg_q.project_length <= cfg_data_i;
        tcm_pkg::CFG_LOOP_ENABLE:    cfg_q.loop_enable    <= cfg_data_i[0];
        tcm_pkg::CFG_LOOP_START:     cfg_q.loop_start     <= cfg_data_i;
        tcm_pkg::CFG_LOOP_END:       cfg_q.loop_end       <= cfg_data_i;
        tcm_pkg::CFG_MONITOR_ENABLE: cfg_q.monitor_enable <= cfg_data_i[0];
        tcm_pkg::CFG_MONITOR_STEREO: cfg_q.monitor_stereo <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcm_engine #(
    .MAX_CLIPS    (MAX_CLIPS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/tcm_checker.sv -----
module tcm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tcm_pkg::out_item_t  out_data_o
);

  logic [15:0] abs_l, abs_r;

  assign abs_l = tcm_pkg::abs16(out_data_o.out_left);
  assign abs_r = tcm_pkg::abs16(out_data_o.out_right);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_non_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |->
      out_data_o.out_left == 16'sd0 && out_data_o.out_right == 16'sd0)
    else $error("non-tick item carries samples");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.peak_left <= 16'h8000 && out_data_o.peak_right <= 16'h8000)
    else $error("peak out of range");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_valid |->
      out_data_o.peak_left >= abs_l && out_data_o.peak_right >= abs_r)
    else $error("peak below current sample");

endmodule

bind timeline_clip_mixer_unit tcm_checker u_tcm_checker (.*);
